// ===== rtl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dp and first_fit_heap_allocator; depends on nothing.
package ffha_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SIZE_W = 21;  // pool_bytes, request_bytes, header size
  localparam int unsigned OFS_W  = 20;  // block_offset, result_offset
  localparam int unsigned ADDR_W = 22;  // byte address math, room for carry

  localparam int unsigned POOL_GRANULES_DEF = 32768;
  localparam int unsigned GRANULE_BYTES_DEF = 32;

  localparam logic [SIZE_W-1:0] POOL_BYTES_RST = 21'h100000;
  // Split only when the tail keeps a header plus this much payload.
  localparam int unsigned MIN_TAIL_BYTES = 64;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_NOFIT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,   // one entry of the clearing pass
    OP_START,   // latch the accepted word, issue the first header read
    OP_WALK,    // evaluate one header of the chain
    OP_SPLIT,   // write the split-off free tail
    OP_FSELF,   // check the header being freed
    OP_FNEXT,   // latch the following header
    OP_FPREV,   // latch the preceding header
    OP_FW1,     // first merge write
    OP_FW2,     // second merge write
    OP_FW3,     // third merge write
    OP_LINKRD,  // read header whose back link changes
    OP_LINKWR,  // write its back link
    OP_LOAD     // move result into the output register
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   cfg_we;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_hit;
    logic walk_miss;
    logic walk_split;
    logic free_skip;
    logic merge_any;
    logic merge_both;
    logic link_ok;
  } dp_sts_t;

endpackage

// ===== rtl/ffha_ram.sv =====
// Header store: one write port, one read port with registered read data.
// No package dependency.
module ffha_ram #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned WIDTH = 38,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/ffha_dp.sv =====
// Datapath: pool limit, walk cursor, free-merge scratch, result registers,
// and the header RAM address/data muxing. Depends on ffha_pkg.
module ffha_dp #(
  parameter int unsigned POOL_GRANULES = ffha_pkg::POOL_GRANULES_DEF,
  parameter int unsigned GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF,
  localparam int unsigned IDX_W = $clog2(POOL_GRANULES),
  localparam int unsigned HDR_W = ffha_pkg::SIZE_W + IDX_W + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffha_pkg::dp_cmd_t            cmd_i,
  output ffha_pkg::dp_sts_t            sts_o,
  input  logic [ffha_pkg::SIZE_W-1:0]  cfg_pool_bytes_i,
  input  logic                         in_mode_i,
  input  logic [ffha_pkg::SIZE_W-1:0]  in_request_bytes_i,
  input  logic [ffha_pkg::OFS_W-1:0]   in_block_offset_i,
  output logic                         out_status_o,
  output logic [ffha_pkg::OFS_W-1:0]   out_result_offset_o,
  output logic                         mem_we_o,
  output logic [IDX_W-1:0]             mem_waddr_o,
  output logic [HDR_W-1:0]             mem_wdata_o,
  output logic [IDX_W-1:0]             mem_raddr_o,
  input  logic [HDR_W-1:0]             mem_rdata_i
);
  import ffha_pkg::*;

  localparam int unsigned GB_BITS = $clog2(GRANULE_BYTES);
  localparam longint unsigned CAP = longint'(POOL_GRANULES) * longint'(GRANULE_BYTES);
  localparam logic [ADDR_W-1:0] GB_A = ADDR_W'(GRANULE_BYTES);
  localparam logic [ADDR_W-1:0] GB_M1 = ADDR_W'(GRANULE_BYTES - 1);
  localparam logic [ADDR_W-1:0] ALIGN_MASK = ~GB_M1;
  localparam logic [ADDR_W:0] MIN_FRAG = (ADDR_W+1)'(GRANULE_BYTES + MIN_TAIL_BYTES);
  localparam logic [IDX_W:0] PG_C = (IDX_W+1)'(POOL_GRANULES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_GRANULES - 1);

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              free;
    logic [IDX_W-1:0]  prev;
    logic              prev_ok;
  } hdr_t;

  function automatic logic [IDX_W-1:0] gidx(input logic [ADDR_W-1:0] a);
    return IDX_W'(a >> GB_BITS);
  endfunction

  // Clamp to capacity, round down to a whole granule.
  function automatic logic [ADDR_W-1:0] pool_limit(input logic [SIZE_W-1:0] v);
    logic [ADDR_W-1:0] c;
    if (64'(v) > CAP) c = ADDR_W'(CAP);
    else              c = ADDR_W'(v);
    return c & ALIGN_MASK;
  endfunction

  logic [ADDR_W-1:0] pool_end_q;
  logic [IDX_W-1:0]  clr_q;

  logic [ADDR_W-1:0] need_q, at_q, start_q, after_q, beyond_q;
  logic [IDX_W:0]    guard_q;
  logic              live_q, fok_q, after_ok_q, beyond_ok_q;
  logic [SIZE_W-1:0] blk_sz_q;
  logic [IDX_W-1:0]  g_q, link_idx_q, link_prev_q;
  logic              link_ok_q, next_free_q, prev_free_q;
  hdr_t              self_q, nxt_q, prv_q;
  logic              res_status_q, out_status_q;
  logic [OFS_W-1:0]  res_offset_q, out_offset_q;

  hdr_t              rd, wd, entry0;
  logic [ADDR_W-1:0] sz_a, at_n, ng_a, ofs_a, start_a, need_in, after_n, beyond_n;
  logic [IDX_W:0]    guard_n;
  logic              walk_hit, walk_miss, walk_split, fok, self_ok, nf, pf;
  logic [IDX_W-1:0]  g_f, ng_f;

  assign rd      = hdr_t'(mem_rdata_i);
  assign sz_a    = ADDR_W'(rd.size);
  assign at_n    = at_q + sz_a;
  assign guard_n = guard_q + 1'b1;
  assign ng_a    = at_q + need_q;

  assign walk_miss  = !live_q || (rd.size == '0);
  assign walk_hit   = !walk_miss && rd.free && (sz_a >= need_q);
  assign walk_split = {1'b0, sz_a} >= ({1'b0, need_q} + MIN_FRAG);

  assign need_in = ((ADDR_W'(in_request_bytes_i) + GB_M1) & ALIGN_MASK) + GB_A;
  assign ofs_a   = ADDR_W'(in_block_offset_i);
  assign start_a = ofs_a - GB_A;
  assign fok     = (ofs_a >= GB_A) && (ofs_a[GB_BITS-1:0] == '0) && (start_a < pool_end_q);

  assign self_ok  = fok_q && (rd.size != '0) && !rd.free;
  assign after_n  = start_q + sz_a;
  assign beyond_n = after_q + sz_a;
  assign nf       = after_ok_q && rd.free && (rd.size != '0);
  assign pf       = self_q.prev_ok && rd.free && (rd.size != '0);
  assign g_f      = gidx(start_q);
  assign ng_f     = gidx(after_q);

  assign entry0 = '{size: SIZE_W'(pool_end_q), free: (pool_end_q != '0),
                    prev: '0, prev_ok: 1'b0};

  // RAM port muxing
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    wd          = '0;
    mem_raddr_o = '0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        wd          = (clr_q == '0) ? entry0 : '0;
      end
      OP_START: begin
        mem_raddr_o = (in_mode_i == MODE_FREE) ? gidx(start_a) : '0;
      end
      OP_WALK: begin
        mem_raddr_o = gidx(at_n);
        mem_we_o    = walk_hit;
        mem_waddr_o = gidx(at_q);
        wd          = '{size: walk_split ? SIZE_W'(need_q) : rd.size, free: 1'b0,
                        prev: rd.prev, prev_ok: rd.prev_ok};
      end
      OP_SPLIT: begin
        mem_raddr_o = link_idx_q;
        mem_we_o    = 1'b1;
        mem_waddr_o = gidx(ng_a);
        wd          = '{size: SIZE_W'(ADDR_W'(blk_sz_q) - need_q), free: 1'b1,
                        prev: g_q, prev_ok: 1'b1};
      end
      OP_FSELF: mem_raddr_o = gidx(after_n);
      OP_FNEXT: mem_raddr_o = self_q.prev;
      OP_FW1: begin
        mem_we_o = 1'b1;
        if (next_free_q && prev_free_q) begin
          mem_waddr_o = self_q.prev;
          wd          = prv_q;
          wd.size     = SIZE_W'(prv_q.size + self_q.size + nxt_q.size);
        end else if (next_free_q) begin
          mem_waddr_o = g_f;
          wd          = self_q;
          wd.size     = SIZE_W'(self_q.size + nxt_q.size);
          wd.free     = 1'b1;
        end else if (prev_free_q) begin
          mem_waddr_o = self_q.prev;
          wd          = prv_q;
          wd.size     = SIZE_W'(prv_q.size + self_q.size);
        end else begin
          mem_waddr_o = g_f;
          wd          = self_q;
          wd.free     = 1'b1;
        end
      end
      OP_FW2: begin
        // absorbed header: self when the previous block grows, else the next one
        mem_we_o    = 1'b1;
        mem_waddr_o = prev_free_q ? g_f : ng_f;
      end
      OP_FW3: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ng_f;
      end
      OP_LINKRD: mem_raddr_o = link_idx_q;
      OP_LINKWR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = link_idx_q;
        wd          = '{size: rd.size, free: rd.free, prev: link_prev_q, prev_ok: 1'b1};
      end
      default: ;
    endcase
  end

  assign mem_wdata_o = HDR_W'(wd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_end_q <= pool_limit(POOL_BYTES_RST);
      clr_q      <= '0;
    end else begin
      if (cmd_i.cfg_we) begin
        pool_end_q <= pool_limit(cfg_pool_bytes_i);
        clr_q      <= '0;
      end else if (cmd_i.op == OP_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        need_q       <= need_in;
        at_q         <= '0;
        guard_q      <= '0;
        live_q       <= (pool_end_q != '0);
        start_q      <= start_a;
        fok_q        <= fok;
        res_status_q <= ST_DONE;
        res_offset_q <= '0;
      end
      OP_WALK: begin
        if (walk_hit) begin
          blk_sz_q     <= rd.size;
          g_q          <= gidx(at_q);
          link_idx_q   <= gidx(at_n);
          link_ok_q    <= (at_n < pool_end_q);
          link_prev_q  <= gidx(ng_a);
          res_status_q <= ST_DONE;
          res_offset_q <= OFS_W'(at_q + GB_A);
        end else if (walk_miss) begin
          res_status_q <= ST_NOFIT;
          res_offset_q <= '0;
        end else begin
          at_q    <= at_n;
          guard_q <= guard_n;
          live_q  <= (at_n < pool_end_q) && (guard_n < PG_C);
        end
      end
      OP_FSELF: begin
        self_q     <= rd;
        after_q    <= after_n;
        after_ok_q <= (after_n < pool_end_q);
      end
      OP_FNEXT: begin
        nxt_q       <= rd;
        next_free_q <= nf;
        beyond_q    <= beyond_n;
        beyond_ok_q <= (beyond_n < pool_end_q);
      end
      OP_FPREV: begin
        prv_q       <= rd;
        prev_free_q <= pf;
        if (next_free_q) begin
          link_idx_q  <= gidx(beyond_q);
          link_ok_q   <= beyond_ok_q;
          link_prev_q <= pf ? self_q.prev : g_f;
        end else begin
          link_idx_q  <= ng_f;
          link_ok_q   <= after_ok_q;
          link_prev_q <= self_q.prev;
        end
      end
      OP_LOAD: begin
        out_status_q <= res_status_q;
        out_offset_q <= res_offset_q;
      end
      default: ;
    endcase
  end

  assign out_status_o        = out_status_q;
  assign out_result_offset_o = out_offset_q;

  always_comb begin
    sts_o.clr_last   = (clr_q == LAST_IDX);
    sts_o.walk_hit   = walk_hit;
    sts_o.walk_miss  = walk_miss;
    sts_o.walk_split = walk_split;
    sts_o.free_skip  = !self_ok;
    sts_o.merge_any  = next_free_q || prev_free_q;
    sts_o.merge_both = next_free_q && prev_free_q;
    sts_o.link_ok    = link_ok_q;
  end

  // A fitted block never grows, and a split tail is always big enough.
  a_fit_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_WALK && walk_hit) |-> (wd.size <= rd.size))
    else $error("fit write larger than the free block");

  a_split_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SPLIT) |-> ((ADDR_W+1)'(blk_sz_q) >= ({1'b0, need_q} + MIN_FRAG)))
    else $error("split leaves a tail below the minimum fragment");

endmodule

// ===== rtl/ffha_ctrl.sv =====
// Controller FSM: clearing pass, allocate walk, free/merge sequence, output hold.
// Depends on ffha_pkg; drives ffha_dp through dp_cmd_t, reads dp_sts_t.
module ffha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ffha_pkg::dp_sts_t sts_i,
  output ffha_pkg::dp_cmd_t cmd_o
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_WALK, S_A_SPLIT, S_F_SELF, S_F_NEXT, S_F_PREV,
    S_F_W1, S_F_W2, S_F_W3, S_LINK_RD, S_LINK_WR, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc, load;

  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign load        = (state_q == S_FINISH) && (!out_valid_q || out_ready_i) && !cfg_valid_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.cfg_we  = cfg_valid_i;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.op = OP_START;
          state_d  = (in_mode_i == MODE_FREE) ? S_F_SELF : S_A_WALK;
        end
      end
      S_A_WALK: begin
        cmd_o.op = OP_WALK;
        if (sts_i.walk_hit)       state_d = sts_i.walk_split ? S_A_SPLIT : S_FINISH;
        else if (sts_i.walk_miss) state_d = S_FINISH;
      end
      S_A_SPLIT: begin
        cmd_o.op = OP_SPLIT;
        state_d  = sts_i.link_ok ? S_LINK_WR : S_FINISH;
      end
      S_F_SELF: begin
        cmd_o.op = OP_FSELF;
        state_d  = sts_i.free_skip ? S_FINISH : S_F_NEXT;
      end
      S_F_NEXT: begin
        cmd_o.op = OP_FNEXT;
        state_d  = S_F_PREV;
      end
      S_F_PREV: begin
        cmd_o.op = OP_FPREV;
        state_d  = S_F_W1;
      end
      S_F_W1: begin
        cmd_o.op = OP_FW1;
        state_d  = sts_i.merge_any ? S_F_W2 : S_FINISH;
      end
      S_F_W2: begin
        cmd_o.op = OP_FW2;
        if (sts_i.merge_both) state_d = S_F_W3;
        else                  state_d = sts_i.link_ok ? S_LINK_RD : S_FINISH;
      end
      S_F_W3: begin
        cmd_o.op = OP_FW3;
        state_d  = sts_i.link_ok ? S_LINK_RD : S_FINISH;
      end
      S_LINK_RD: begin
        cmd_o.op = OP_LINKRD;
        state_d  = S_LINK_WR;
      end
      S_LINK_WR: begin
        cmd_o.op = OP_LINKWR;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (load) begin
          cmd_o.op    = OP_LOAD;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    // a pool write always restarts the clearing pass
    if (cfg_valid_i) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (state_q == S_CLEAR))
    else $error("pool write did not restart the clearing pass");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_valid_q && !out_ready_i && !cfg_valid_i)
      |=> (state_q == S_FINISH && out_valid_q))
    else $error("result loaded over a pending word");

  a_accept_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_A_WALK || state_q == S_F_SELF))
    else $error("accepted word did not start an operation");

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator with neighbor coalescing.
// Instantiates ffha_ctrl, ffha_dp and ffha_ram; depends on ffha_pkg.
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+-----------------------------------------
//  cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_pool_bytes_i (pool size, rebuilds pool)
//  in      | in  | in_valid_i/in_ready_o   | in_mode_i, in_request_bytes_i, in_block_offset_i
//  out     | out | out_valid_o/out_ready_i | out_status_o, out_result_offset_o
//
// Allocate reads the header chain from address 0, one header a cycle through the
// registered read port of the header RAM (the fitting or ending one included),
// then writes the split-off tail when it splits and rewrites the back link of the
// block after the tail when there is one. Free reads the freed header and stops
// when the offset is ignored; else it does three header reads, up to three merge
// writes and a read-modify-write of the following block's back link.
// Reset and every pool_bytes write run a clearing pass over every entry of the
// header RAM; in_ready_o stays low during it, cfg_ready_o stays high.
// Results sit in an output register: a new word is taken while one waits there,
// and a finished result holds the datapath only while the output is still full.
module first_fit_heap_allocator #(
  parameter int unsigned POOL_GRANULES = ffha_pkg::POOL_GRANULES_DEF,
  parameter int unsigned GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF  // power of two
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ffha_pkg::SIZE_W-1:0] cfg_pool_bytes_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_mode_i,
  input  logic [ffha_pkg::SIZE_W-1:0] in_request_bytes_i,
  input  logic [ffha_pkg::OFS_W-1:0]  in_block_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_status_o,
  output logic [ffha_pkg::OFS_W-1:0]  out_result_offset_o
);
  import ffha_pkg::*;

  localparam int unsigned IDX_W = $clog2(POOL_GRANULES);
  // header: size, free mark, previous block granule, previous-valid
  localparam int unsigned HDR_W = SIZE_W + IDX_W + 2;

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [HDR_W-1:0] mem_wdata, mem_rdata;

  // Pool writes are always taken; the user issues them only with the block idle, unenforced.
  assign cfg_ready_o = 1'b1;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_mode_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffha_dp #(
    .POOL_GRANULES (POOL_GRANULES),
    .GRANULE_BYTES (GRANULE_BYTES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_pool_bytes_i    (cfg_pool_bytes_i),
    .in_mode_i           (in_mode_i),
    .in_request_bytes_i  (in_request_bytes_i),
    .in_block_offset_i   (in_block_offset_i),
    .out_status_o        (out_status_o),
    .out_result_offset_o (out_result_offset_o),
    .mem_we_o            (mem_we),
    .mem_waddr_o         (mem_waddr),
    .mem_wdata_o         (mem_wdata),
    .mem_raddr_o         (mem_raddr),
    .mem_rdata_i         (mem_rdata)
  );

  ffha_ram #(
    .DEPTH (POOL_GRANULES),
    .WIDTH (HDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== tb/first_fit_heap_allocator_test.sv =====
// Self-checking testbench of first_fit_heap_allocator: directed and random allocate/free
// traffic over several pool sizes, checked against an in-bench heap model.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
module first_fit_heap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;

  // Geometry of the default build.
  localparam int unsigned GRAN_B = GRANULE_BYTES_DEF;
  localparam int unsigned N_GRAN = POOL_GRANULES_DEF;
  localparam int unsigned GIDX_W = $clog2(N_GRAN);
  localparam longint unsigned CAPACITY = longint'(N_GRAN) * GRAN_B;
  // A split needs room for a header plus the minimum payload in the tail.
  localparam int unsigned SPLIT_SLACK = GRAN_B + MIN_TAIL_BYTES;
  // Worst case: ~850 words each walking a few hundred headers, stalled on both
  // sides, plus one clearing pass per pool write. This is several times that.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic             status;
    logic [OFS_W-1:0] offset;
  } result_t;

  logic              clk_i;
  logic              rst_ni              = 1'b0;
  logic              cfg_valid_i         = 1'b0;
  logic              cfg_ready_o;
  logic [SIZE_W-1:0] cfg_pool_bytes_i    = '0;
  logic              in_valid_i          = 1'b0;
  logic              in_ready_o;
  logic              in_mode_i           = MODE_ALLOC;
  logic [SIZE_W-1:0] in_request_bytes_i  = '0;
  logic [OFS_W-1:0]  in_block_offset_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i         = 1'b0;
  logic              out_status_o;
  logic [OFS_W-1:0]  out_result_offset_o;

  first_fit_heap_allocator i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_pool_bytes_i    (cfg_pool_bytes_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .in_mode_i           (in_mode_i),
    .in_request_bytes_i  (in_request_bytes_i),
    .in_block_offset_i   (in_block_offset_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_status_o        (out_status_o),
    .out_result_offset_o (out_result_offset_o)
  );

  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  // ---------------------------------------------------------------------------
  // Heap model: one header per granule, same layout as the block keeps.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] hdr_size    [N_GRAN];  // 0: no block starts here
  logic              hdr_free    [N_GRAN];
  logic [GIDX_W-1:0] hdr_prev    [N_GRAN];  // granule of the block before
  logic              hdr_prev_ok [N_GRAN];
  longint unsigned   pool_end;              // usable bytes after clamp and rounding

  result_t         answers_due[$];   // allocator answers not yet seen at the output
  int unsigned     live_offsets[$];  // user offsets currently handed out
  int unsigned     last_freed;
  int unsigned     mismatch_count;
  int unsigned     cycle_count;
  int unsigned     burst_left;       // words left in the current sender burst
  int unsigned     stall_mode;
  int unsigned     stall_left;

  function automatic logic [GIDX_W-1:0] granule_of(longint unsigned addr);
    return GIDX_W'((addr / GRAN_B) % N_GRAN);
  endfunction

  function automatic void clear_header(logic [GIDX_W-1:0] g);
    hdr_size[g]    = '0;
    hdr_free[g]    = 1'b0;
    hdr_prev[g]    = '0;
    hdr_prev_ok[g] = 1'b0;
  endfunction

  // Back link of the block at addr, if that block lies inside the pool.
  function automatic void link_prev(longint unsigned addr, logic [GIDX_W-1:0] pg);
    logic [GIDX_W-1:0] g;
    if (addr < pool_end) begin
      g = granule_of(addr);
      hdr_prev[g]    = pg;
      hdr_prev_ok[g] = 1'b1;
    end
  endfunction

  // A pool write (or reset) leaves one free block spanning the whole pool.
  function automatic void rebuild_pool(logic [SIZE_W-1:0] bytes);
    longint unsigned sz;
    sz = bytes;
    if (sz > CAPACITY) sz = CAPACITY;
    sz = sz / GRAN_B * GRAN_B;
    pool_end = sz;
    for (int g = 0; g < N_GRAN; g++) clear_header(GIDX_W'(g));
    if (sz != 0) begin
      hdr_size[0] = SIZE_W'(sz);
      hdr_free[0] = 1'b1;
    end
    live_offsets.delete();
  endfunction

  // First fit from address 0; split off the tail when it can hold a block.
  function automatic result_t carve_block(longint unsigned req);
    longint unsigned   need;
    longint unsigned   at;
    longint unsigned   sz;
    logic [GIDX_W-1:0] g;
    logic [GIDX_W-1:0] ng;
    int unsigned       guard;
    result_t           res;
    need       = (req + GRAN_B - 1) / GRAN_B * GRAN_B + GRAN_B;
    at         = 0;
    guard      = 0;
    res.status = ST_NOFIT;
    res.offset = '0;
    while (at < pool_end && guard < N_GRAN) begin
      g  = granule_of(at);
      sz = hdr_size[g];
      if (sz == 0) break;
      if (hdr_free[g] && sz >= need) begin
        hdr_free[g] = 1'b0;
        if (sz >= need + SPLIT_SLACK) begin
          ng              = granule_of(at + need);
          hdr_size[ng]    = SIZE_W'(sz - need);
          hdr_free[ng]    = 1'b1;
          hdr_prev[ng]    = g;
          hdr_prev_ok[ng] = 1'b1;
          link_prev(at + sz, ng);
          hdr_size[g]     = SIZE_W'(need);
        end
        res.status = ST_DONE;
        res.offset = OFS_W'(at + GRAN_B);
        return res;
      end
      at += sz;
      guard++;
    end
    return res;
  endfunction

  // Mark the block free and merge with free neighbors; bad offsets change nothing.
  function automatic void give_back_block(longint unsigned ofs);
    longint unsigned   start;
    longint unsigned   after;
    longint unsigned   beyond;
    logic [GIDX_W-1:0] g;
    logic [GIDX_W-1:0] ng;
    logic [GIDX_W-1:0] pg;
    logic              next_free;
    logic              prev_free;
    ng        = '0;
    pg        = '0;
    next_free = 1'b0;
    prev_free = 1'b0;
    if (ofs < GRAN_B) return;
    start = ofs - GRAN_B;
    if (start % GRAN_B != 0 || start >= pool_end) return;
    g = granule_of(start);
    if (hdr_size[g] == 0 || hdr_free[g]) return;

    after = start + hdr_size[g];
    if (after < pool_end) begin
      ng        = granule_of(after);
      next_free = hdr_free[ng] && hdr_size[ng] != 0;
    end
    if (hdr_prev_ok[g]) begin
      pg        = hdr_prev[g];
      prev_free = hdr_free[pg] && hdr_size[pg] != 0;
    end

    if (next_free) begin
      beyond = after + hdr_size[ng];
      if (prev_free) begin
        hdr_size[pg] = hdr_size[pg] + hdr_size[g] + hdr_size[ng];
        clear_header(g);
        clear_header(ng);
        link_prev(beyond, pg);
      end else begin
        hdr_free[g] = 1'b1;
        hdr_size[g] = hdr_size[g] + hdr_size[ng];
        clear_header(ng);
        link_prev(beyond, g);
      end
    end else if (prev_free) begin
      hdr_size[pg] = hdr_size[pg] + hdr_size[g];
      clear_header(g);
      link_prev(after, pg);
    end else begin
      hdr_free[g] = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking and output side
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // Compares every accepted result word with the oldest answer due, then picks
  // the next out_ready_i from a pattern that switches between always ready,
  // mostly ready and mostly stalled.
  always @(posedge clk_i) begin : check_words
    result_t want;
    if (out_valid_o && out_ready_i) begin
      if (answers_due.size() == 0) begin
        flag_mismatch("word with nothing due (offset shown)", 0, out_result_offset_o);
      end else begin
        want = answers_due.pop_front();
        if (out_status_o !== want.status)
          flag_mismatch("status", want.status, out_status_o);
        if (out_result_offset_o !== want.offset)
          flag_mismatch("result_offset", want.offset, out_result_offset_o);
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(2);
      stall_left = $urandom_range(120, 20);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(3) != 0);
      default: out_ready_i <= ($urandom_range(6) == 0);
    endcase
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Sends one word, bursty: between bursts valid drops for a random gap. Valid is
  // left high after acceptance so a back-to-back word needs no second assignment.
  // The answer is predicted at the accepting edge and handed back to the caller.
  task automatic offer_word(input logic mode, input logic [SIZE_W-1:0] req,
                            input logic [OFS_W-1:0] ofs, output result_t res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      burst_left = $urandom_range(24, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i         <= 1'b1;
    in_mode_i          <= mode;
    in_request_bytes_i <= req;
    in_block_offset_i  <= ofs;
    do @(posedge clk_i); while (!in_ready_o);
    if (mode == MODE_ALLOC) begin
      res = carve_block(req);
    end else begin
      give_back_block(ofs);
      res.status = ST_DONE;
      res.offset = '0;
    end
    answers_due.push_back(res);
  endtask

  // Drop valid and wait until every answer has come out. Always spends at least
  // one edge so valid is never lowered and raised in the same step.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (answers_due.size() != 0);
  endtask

  // Pool writes only go in while nothing is in flight; the clearing pass that
  // follows just shows up as in_ready_o low for the next word.
  task automatic write_pool(logic [SIZE_W-1:0] bytes);
    wait_idle();
    cfg_valid_i      <= 1'b1;
    cfg_pool_bytes_i <= bytes;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rebuild_pool(bytes);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset pool: one request that takes every byte, then the edges of both fields.
  task automatic test_full_pool();
    result_t whole;
    result_t r;
    offer_word(MODE_ALLOC, SIZE_W'(CAPACITY - GRAN_B), '0, whole);
    offer_word(MODE_ALLOC, '0, '0, r);              // nothing left
    offer_word(MODE_FREE, '0, whole.offset, r);
    offer_word(MODE_FREE, '0, whole.offset, r);     // already free
    offer_word(MODE_ALLOC, '1, '0, r);              // largest request, no fit
    offer_word(MODE_FREE, '1, '1, r);               // top offset, unaligned
  endtask

  // Splits, then every merge shape: next only, none, both, prev only.
  task automatic test_split_merge();
    result_t a, b, c, d, x, y, z, r;
    offer_word(MODE_ALLOC, 0, '0, a);
    offer_word(MODE_ALLOC, 1, '0, b);
    offer_word(MODE_ALLOC, 100, '0, c);
    offer_word(MODE_ALLOC, 0, '0, d);
    offer_word(MODE_FREE, '0, d.offset, r);  // merges into the tail
    offer_word(MODE_FREE, '0, a.offset, r);  // no free neighbor
    offer_word(MODE_FREE, '0, c.offset, r);  // merges into the tail
    offer_word(MODE_FREE, '0, b.offset, r);  // both sides
    offer_word(MODE_ALLOC, 0, '0, x);
    offer_word(MODE_ALLOC, 0, '0, y);
    offer_word(MODE_ALLOC, 0, '0, z);
    offer_word(MODE_FREE, '0, x.offset, r);
    offer_word(MODE_FREE, '0, y.offset, r);  // previous only, z still held
  endtask

  // 96-byte pool: a header-only request fits and gets the whole pool, no split.
  task automatic test_tiny_pool();
    result_t a, r;
    write_pool(96);
    offer_word(MODE_ALLOC, 0, '0, a);
    offer_word(MODE_ALLOC, 0, '0, r);
    offer_word(MODE_FREE, '0, a.offset, r);
  endtask

  // Pool rounds down to zero bytes: no blocks at all.
  task automatic test_empty_pool();
    result_t r;
    write_pool(SIZE_W'(GRAN_B - 1));
    offer_word(MODE_ALLOC, 0, '0, r);
    offer_word(MODE_FREE, '0, OFS_W'(GRAN_B), r);
  endtask

  // Oversized write clamps to capacity; an unaligned size rounds down.
  task automatic test_clamp_and_round();
    result_t r;
    write_pool('1);
    offer_word(MODE_ALLOC, SIZE_W'(CAPACITY - GRAN_B), '0, r);
    write_pool(1000);
    offer_word(MODE_FREE, '0, OFS_W'(992 + GRAN_B), r);  // past the end of the pool
    offer_word(MODE_ALLOC, 928, '0, r);                  // leaves too little to split
  endtask

  // Mostly well-formed churn (allocate, free of a live offset) with some noise:
  // double frees, unaligned or interior offsets, offsets below the header or
  // past the pool, and requests over the full field width.
  task automatic heap_churn(int unsigned n_words, int unsigned max_req);
    int unsigned       pick;
    int unsigned       idx;
    int unsigned       ofs;
    logic [SIZE_W-1:0] req;
    result_t           res;
    repeat (n_words) begin
      pick = $urandom_range(99);
      if (live_offsets.size() == 0 || pick < 50) begin
        case ($urandom_range(9))
          0:       req = SIZE_W'($urandom);
          1:       req = SIZE_W'($urandom_range(32'(pool_end)));
          2, 3:    req = SIZE_W'($urandom_range(SPLIT_SLACK));  // granule and split edges
          default: req = SIZE_W'($urandom_range(max_req));
        endcase
        offer_word(MODE_ALLOC, req, OFS_W'($urandom), res);
        if (res.status == ST_DONE && res.offset != 0) live_offsets.push_back(res.offset);
      end else if (pick < 88) begin
        idx = $urandom_range(live_offsets.size() - 1);
        ofs = live_offsets[idx];
        live_offsets.delete(idx);
        last_freed = ofs;
        offer_word(MODE_FREE, SIZE_W'($urandom), OFS_W'(ofs), res);
      end else begin
        case ($urandom_range(4))
          0: ofs = last_freed;
          1: ofs = $urandom;
          2: ofs = $urandom_range(GRAN_B - 1);
          3: ofs = live_offsets[$urandom_range(live_offsets.size() - 1)]
                   + $urandom_range(4 * GRAN_B, 1);
          default: ofs = 32'(pool_end + GRAN_B + $urandom_range(8) * GRAN_B);
        endcase
        offer_word(MODE_FREE, SIZE_W'($urandom), OFS_W'(ofs), res);
      end
    end
  endtask

  task automatic test_random_small_pool();
    write_pool(4096);
    heap_churn(290, 256);
  endtask

  task automatic test_random_odd_pool();
    write_pool(SIZE_W'($urandom_range(24000, 6000)));
    heap_churn(265, 1024);
  endtask

  task automatic test_random_full_pool();
    write_pool(SIZE_W'(CAPACITY));
    heap_churn(265, 16384);
  endtask

  initial begin
    rebuild_pool(POOL_BYTES_RST);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_full_pool();
    test_split_merge();
    test_tiny_pool();
    test_empty_pool();
    test_clamp_and_round();
    test_random_small_pool();
    test_random_odd_pool();
    test_random_full_pool();

    // Let any stray word show up before the verdict.
    wait_idle();
    repeat (64) @(posedge clk_i);
    if (answers_due.size() != 0) flag_mismatch("answers never seen", 0, answers_due.size());
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_dp.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_test.sv
